### sv/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants of the integer text formatter
// Field widths, character constants and the descriptor that runs from the
// front end to the emitter.
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 63;
    localparam int FIELD_CAP      = 64;
    // a 64-bit magnitude has at most 20 decimal or 16 hex digits
    localparam int CONV_DIGITS    = 20;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [63:0] magnitude;
        logic        hex_base;
        logic        upper_case;
        logic        negative;
        logic        force_plus;
        logic        space_sign;
        logic        left_align;
        logic        zero_pad;
        logic [5:0]  field_width;
        logic [6:0]  min_digits;
        logic [15:0] room;
    } t_in_word;

    typedef struct packed {
        logic [7:0] character;
        logic [5:0] position;
        logic       last;
    } t_out_word;

    // one converted digit string plus the field layout
    typedef struct packed {
        logic [CONV_DIGITS-1:0][3:0] digits; // digit k is k-th least significant
        logic [6:0]                ndig;   // digits from the conversion, 1..20
        logic [6:0]                nout;   // digits printed incl. leading zeros
        logic [7:0]                sign_ch;
        logic                      has_sign;
        logic [6:0]                pad;
        logic                      pad_front; // spaces before sign
        logic                      pad_zero;  // zeros after sign
        logic                      pad_back;  // spaces after digits
        logic                      upper_case;
        logic [6:0]                len;       // chars to emit, 0..64
    } t_job;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_LAYOUT,
        FE_PUSH
    } t_fe_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
        logic [7:0] c;
        if (d < 4'd10) c = CH_ZERO + {4'd0, d};
        else if (up)   c = 8'h37 + {4'd0, d};
        else           c = 8'h57 + {4'd0, d};
        return c;
    endfunction

endpackage

### sv/itf_if.sv
// ----------------------------------------------------------------------------
// itf_if: valid/ready channel
// Generic stream channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface itf_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/itf_front.sv
// ----------------------------------------------------------------------------
// itf_front: digit conversion and field layout
// Converts the magnitude to digits, one per cycle for hex (a 4-bit shift);
// decimal divides by 10 via a reciprocal estimate that is registered and then
// corrected. Then computes the field layout and pushes a job descriptor.
// ----------------------------------------------------------------------------
module itf_front #(
    parameter int MAX_DIGITS = itf_pkg::MAX_DIGITS_DEF,
    parameter int MAX_WIDTH  = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    itf_if.sink                 in_ch,
    output logic                o_job_valid,
    output itf_pkg::t_job       o_job,
    input  logic                i_job_ready
);
    localparam int CAP = itf_pkg::FIELD_CAP;
    localparam int NDG = itf_pkg::CONV_DIGITS;

    itf_pkg::t_fe_state r_state, n_state;
    itf_pkg::t_in_word  r_in;
    logic [63:0]        r_val;
    logic               r_phase;      // decimal: 0 multiply, 1 correct
    logic [63:0]        r_q;
    logic [NDG-1:0][3:0] r_dig;
    logic [6:0]         r_nd;
    itf_pkg::t_job      r_job;

    // q = floor(v/10) estimate from a 64x64 high product built as four 32x32
    // partials would be costly; use v/10 = (v>>1)/5 with a shift-add reciprocal
    // chain, registered, then corrected next cycle.
    logic [63:0] w_half;
    logic [63:0] w_est;
    logic [63:0] w_rem;
    logic [63:0] w_qc;
    logic [3:0]  w_dd;

    always_comb begin
        w_half = r_val >> 1;
        // (x*0xCCCC...CCD)>>66 approximated by shift-add: q ~ x*0.8 /4
        w_est = (w_half >> 1) + (w_half >> 2);
        w_est = w_est + (w_est >> 4);
        w_est = w_est + (w_est >> 8);
        w_est = w_est + (w_est >> 16);
        w_est = w_est + (w_est >> 32);
        w_est = w_est >> 2;
    end

    // correction: remainder below 10*k, settle with small compares
    always_comb begin
        w_rem = r_val - ((r_q << 3) + (r_q << 1));
        w_qc  = r_q;
        if (w_rem >= 64'd30) begin
            w_qc = r_q + 64'd3; w_rem = w_rem - 64'd30;
        end else if (w_rem >= 64'd20) begin
            w_qc = r_q + 64'd2; w_rem = w_rem - 64'd20;
        end else if (w_rem >= 64'd10) begin
            w_qc = r_q + 64'd1; w_rem = w_rem - 64'd10;
        end
        w_dd = w_rem[3:0];
    end

    // layout
    logic [6:0] w_mind, w_nout, w_width, w_used, w_pad, w_total;
    logic [7:0] w_sign;
    logic       w_hs, w_left, w_zp;
    always_comb begin
        w_left = r_in.left_align;
        w_zp   = r_in.zero_pad & ~r_in.left_align;
        w_mind = r_in.min_digits[6] ? 7'd0 : r_in.min_digits;
        if (w_mind > 7'(MAX_DIGITS)) w_mind = 7'(MAX_DIGITS);
        w_nout = (r_nd > w_mind) ? r_nd : w_mind;
        w_width = {1'b0, r_in.field_width};
        if (w_width > 7'(MAX_WIDTH)) w_width = 7'(MAX_WIDTH);
        w_hs = r_in.negative | r_in.force_plus | r_in.space_sign;
        w_sign = r_in.negative ? itf_pkg::CH_MINUS :
                 r_in.force_plus ? itf_pkg::CH_PLUS : itf_pkg::CH_SPACE;
        w_used = w_nout + {6'd0, w_hs};
        w_pad  = (w_width > w_used) ? w_width - w_used : 7'd0;
        w_total = (w_width > w_used) ? w_width : w_used;
        if (w_total > 7'(CAP)) w_total = 7'(CAP);
        if (r_in.room < 16'd2) w_total = 7'd0;
        else if ({9'd0, w_total} > r_in.room - 16'd1)
            w_total = r_in.room[6:0] - 7'd1;
    end

    logic w_conv_done;
    always_comb begin
        if (r_in.hex_base) w_conv_done = (r_val[63:4] == 60'd0);
        else               w_conv_done = r_phase && (w_qc == 64'd0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itf_pkg::FE_IDLE:   if (in_ch.valid) n_state = itf_pkg::FE_CONV;
            itf_pkg::FE_CONV:   if (w_conv_done) n_state = itf_pkg::FE_LAYOUT;
            itf_pkg::FE_LAYOUT: n_state = itf_pkg::FE_PUSH;
            itf_pkg::FE_PUSH:   if (i_job_ready) n_state = itf_pkg::FE_IDLE;
            default:            n_state = itf_pkg::FE_IDLE;
        endcase
    end

    always_comb begin
        in_ch.ready = (r_state == itf_pkg::FE_IDLE);
        o_job_valid = (r_state == itf_pkg::FE_PUSH);
        o_job       = r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itf_pkg::FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_in    <= in_ch.data;
            r_val   <= in_ch.data.magnitude;
            r_phase <= 1'b0;
            r_dig   <= '0;
            r_nd    <= 7'd0;
        end else if (r_state == itf_pkg::FE_CONV) begin
            if (r_in.hex_base) begin
                r_dig[r_nd[4:0]] <= r_val[3:0];
                r_nd  <= r_nd + 7'd1;
                r_val <= r_val >> 4;
            end else if (!r_phase) begin
                r_q     <= w_est;
                r_phase <= 1'b1;
            end else begin
                r_dig[r_nd[4:0]] <= w_dd;
                r_nd    <= r_nd + 7'd1;
                r_val   <= w_qc;
                r_phase <= 1'b0;
            end
        end
        // digit count is final here; the job is shown valid from the next cycle
        if (r_state == itf_pkg::FE_LAYOUT) begin
            r_job.digits     <= r_dig;
            r_job.ndig       <= r_nd;
            r_job.nout       <= w_nout;
            r_job.sign_ch    <= w_sign;
            r_job.has_sign   <= w_hs;
            r_job.pad        <= w_pad;
            r_job.pad_front  <= ~w_zp & ~w_left;
            r_job.pad_zero   <= w_zp;
            r_job.pad_back   <= w_left;
            r_job.upper_case <= r_in.upper_case;
            r_job.len        <= w_total;
        end
    end

`ifndef SYNTHESIS
    a_nd_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itf_pkg::FE_CONV) |-> r_nd < 7'(NDG))
        else $error("digit count overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !o_job_valid) else $error("accept while pushing");
    a_conv_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> r_state == itf_pkg::FE_CONV)
        else $error("conversion did not start");
`endif
endmodule

### sv/itf_back.sv
// ----------------------------------------------------------------------------
// itf_back: character emitter
// Pops a job, walks the field one character per cycle, while the receiver
// does not stall, into an output register.
// ----------------------------------------------------------------------------
module itf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  itf_pkg::t_job i_job,
    output logic          o_job_ready,
    itf_if.source         out_ch
);
    logic          r_busy;
    itf_pkg::t_job r_job;
    logic [6:0]    r_pos;
    logic          r_ov;
    itf_pkg::t_out_word r_ow;

    logic [6:0] w_a, w_b, w_c, w_d;
    logic [6:0] w_di;
    logic [7:0] w_ch;
    always_comb begin
        // segment boundaries
        w_a = r_job.pad_front ? r_job.pad : 7'd0;
        w_b = w_a + {6'd0, r_job.has_sign};
        w_c = w_b + (r_job.pad_zero ? r_job.pad : 7'd0);
        w_d = w_c + r_job.nout;
        w_di = w_d - 7'd1 - r_pos;
        if (r_pos < w_a)      w_ch = itf_pkg::CH_SPACE;
        else if (r_pos < w_b) w_ch = r_job.sign_ch;
        else if (r_pos < w_c) w_ch = itf_pkg::CH_ZERO;
        else if (r_pos < w_d) begin
            if (w_di < r_job.ndig)
                w_ch = itf_pkg::digit_char(r_job.digits[w_di[4:0]], r_job.upper_case);
            else
                w_ch = itf_pkg::CH_ZERO;
        end else              w_ch = itf_pkg::CH_SPACE;
    end

    logic w_load, w_step;
    assign o_job_ready = !r_busy;
    assign w_load = i_job_valid && !r_busy;
    assign w_step = r_busy && (!r_ov || out_ch.ready);
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_ow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= (i_job.len != 7'd0);
                r_job  <= i_job;
                r_pos  <= 7'd0;
            end else if (w_step) begin
                r_ov  <= 1'b1;
                r_ow.character <= w_ch;
                r_ow.position  <= r_pos[5:0];
                r_ow.last      <= (r_pos + 7'd1 == r_job.len);
                r_pos <= r_pos + 7'd1;
                if (r_pos + 7'd1 == r_job.len) r_busy <= 1'b0;
            end
            if (!w_step && r_ov && out_ch.ready) r_ov <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pos < r_job.len) else $error("position overrun");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> $stable(r_ow)) else $error("word changed");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !out_ch.ready) |=> r_ov)
        else $error("valid dropped while stalled");
`endif
endmodule

### sv/integer_to_text_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_text_formatter_core: printf-style integer field formatter
// Turns a 64-bit magnitude and format flags into ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per integer to print (magnitude and format flags).
//   out_ch : one word per character, with its position and a last mark.
//   Sequence: hex conversion shifts out each digit; decimal forms each digit
//   as a reciprocal estimate, then a correction. Layout, hand-off and the
//   output register follow before the first character shows.
//   Throughput: one character per cycle from the emitter while the receiver
//   does not stall. The front converts the next word while the emitter still
//   drains the previous one.
//   A field whose room is below two produces no characters.
//   Reset (i_rst_n low, synchronous) empties both halves.
//   When the receiver stalls, the output register holds its word and the
//   emitter, then the front end, stop in turn.
// ----------------------------------------------------------------------------
module integer_to_text_formatter_core #(
    parameter int MAX_DIGITS = itf_pkg::MAX_DIGITS_DEF,
    parameter int MAX_WIDTH  = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    itf_if.sink   in_ch,
    itf_if.source out_ch
);
    logic          w_jv, w_jr;
    itf_pkg::t_job w_job;

    itf_front #(.MAX_DIGITS(MAX_DIGITS), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_job_valid(w_jv), .o_job(w_job), .i_job_ready(w_jr)
    );

    itf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(w_jv), .i_job(w_job),
        .o_job_ready(w_jr), .out_ch(out_ch)
    );
endmodule
